// File: rtl/room_relay_keycard_controller_core_macros.svh
// Assertion helpers for the room relay and keycard controller.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef ROOM_RELAY_KEYCARD_CONTROLLER_CORE_MACROS_SVH
`define ROOM_RELAY_KEYCARD_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication.
`define RRKC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RRKC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rrkc_pkg.sv
package rrkc_pkg;

	localparam int NUM_BUTTONS = 24;
	localparam int NUM_RELAYS  = 16;
	localparam int CNT_W       = 24;
	localparam int CFG_IDX_W   = 2;

	typedef enum logic {
		OP_SCAN = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BELL_TIMEOUT = 2'd0,
		CFG_CARD_INSERT  = 2'd1,
		CFG_CARD_REMOVE  = 2'd2
	} cfg_idx_t;

	localparam logic [CNT_W-1:0] BELL_TIMEOUT_RST = 24'd1000;
	localparam logic [CNT_W-1:0] CARD_INSERT_RST  = 24'd100;
	localparam logic [CNT_W-1:0] CARD_REMOVE_RST  = 24'd1000;

	// Button positions
	localparam int B_MUR_OUT = 0;
	localparam int B_DND_OUT = 1;
	localparam int B_BELL    = 2;
	localparam int B_UNUSED  = 6;
	localparam int B_SL1     = 7;
	localparam int B_S9      = 8;
	localparam int B_BATH1   = 9;
	localparam int B_BATH2   = 13;
	localparam int B_MASTER  = 14;
	localparam int B_SPARE_A = 17;
	localparam int B_SPARE_B = 18;
	localparam int B_MUR_IN  = 19;
	localparam int B_DND_IN  = 20;
	localparam int B_SPARE_C = 21;
	localparam int B_SPARE_D = 22;
	localparam int B_CARD    = 23;

	// Relay numbers, counted from one
	localparam int R_BELL    = 13;
	localparam int R_LOBBY   = 8;
	localparam int R_WELC_A  = 12;
	localparam int R_WELC_B  = 11;
	localparam int R_WELC_C  = 15;
	localparam int R_BATH    = 9;

	localparam int NUM_TOGGLES = 12;
	localparam int TOG_BUTTON [NUM_TOGGLES] = '{3, 4, 5, 7, 8, 9, 10, 11, 12, 13, 15, 16};
	localparam int TOG_RELAY  [NUM_TOGGLES] = '{7, 6, 3, 8, 15, 9, 10, 1, 16, 9, 2, 14};

	function automatic logic [NUM_RELAYS-1:0] rly(input int n);
		rly = NUM_RELAYS'(1) << (n - 1);
	endfunction

	function automatic logic [NUM_BUTTONS-1:0] btn(input int i);
		btn = NUM_BUTTONS'(1) << i;
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		bump = (c == '1) ? c : c + CNT_W'(1);
	endfunction

	// Master hold keeps only the lobby relay and welcome relays A and B, not welcome relay C
	localparam logic [NUM_RELAYS-1:0] MASTER_RLY_KEEP =
		rly(R_LOBBY) | rly(R_WELC_A) | rly(R_WELC_B);
	localparam logic [NUM_BUTTONS-1:0] MASTER_LED_KEEP =
		btn(B_BELL) | btn(B_MASTER) | btn(B_UNUSED) | btn(B_CARD);
	localparam logic [NUM_RELAYS-1:0] WELCOME_RLY =
		rly(R_WELC_A) | rly(R_WELC_B) | rly(R_WELC_C) | rly(R_LOBBY);

	typedef struct packed {
		logic [NUM_RELAYS-1:0]  relay;
		logic [NUM_BUTTONS-1:0] led;
		logic                   dnd;
		logic                   master;
		logic                   bell_run;
		logic [CNT_W-1:0]       bell_cnt;
		logic                   card_present;
		logic                   card_en;
		logic [CNT_W-1:0]       ins_cnt;
		logic [CNT_W-1:0]       abs_cnt;
	} ctl_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] bell_timeout;
		logic [CNT_W-1:0] card_insert;
		logic [CNT_W-1:0] card_remove;
	} cfg_t;

endpackage

// File: rtl/rrkc_cfg_regs.sv
module rrkc_cfg_regs
	import rrkc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CNT_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bell_timeout <= BELL_TIMEOUT_RST;
			cfg_q.card_insert  <= CARD_INSERT_RST;
			cfg_q.card_remove  <= CARD_REMOVE_RST;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_BELL_TIMEOUT: cfg_q.bell_timeout <= wr_data;
				CFG_CARD_INSERT:  cfg_q.card_insert  <= wr_data;
				CFG_CARD_REMOVE:  cfg_q.card_remove  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/rrkc_room_state.sv
module rrkc_room_state
	import rrkc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  op_t                    op,
	input  logic [NUM_BUTTONS-1:0] press_mask,
	input  logic [NUM_BUTTONS-1:0] release_mask,
	input  cfg_t                   cfg,
	output ctl_state_t             state,
	output ctl_state_t             nxt
);

	ctl_state_t state_q;

	always_comb begin
		logic [CNT_W-1:0] cnt;
		logic             lvl;
		nxt = state_q;
		cnt = '0;
		lvl = 1'b0;
		if (op == OP_TICK) begin
			if (state_q.bell_run) begin
				cnt = bump(state_q.bell_cnt);
				nxt.bell_cnt = cnt;
				if (cnt >= cfg.bell_timeout) begin
					nxt.relay[R_BELL-1] = 1'b0;
					nxt.bell_cnt        = '0;
					nxt.bell_run        = 1'b0;
				end
			end
			if (state_q.card_present) begin
				cnt = bump(state_q.ins_cnt);
				nxt.ins_cnt = cnt;
				nxt.abs_cnt = '0;
				if (cnt >= cfg.card_insert) begin
					nxt.ins_cnt = '0;
					if (!state_q.card_en) begin
						nxt.relay      = nxt.relay | WELCOME_RLY;
						nxt.led[B_SL1] = 1'b1;
						nxt.led[B_S9]  = 1'b1;
						nxt.card_en    = 1'b1;
					end
				end
			end else begin
				cnt = bump(state_q.abs_cnt);
				nxt.abs_cnt = cnt;
				if (cnt >= cfg.card_remove) begin
					nxt.abs_cnt = '0;
					nxt.card_en = 1'b0;
					nxt.relay   = '0;
					nxt.led     = '0;
					nxt.dnd     = 1'b0;
				end
			end
		end else begin
			if (press_mask[B_BELL]) begin
				nxt.led[B_BELL] = 1'b1;
				if (!state_q.dnd) begin
					nxt.relay[R_BELL-1] = 1'b1;
					nxt.bell_run        = 1'b1;
				end
			end else if (release_mask[B_BELL]) begin
				nxt.led[B_BELL] = 1'b0;
			end
			// Only the two bath buttons share a relay; walk the list in order
			for (int k = 0; k < NUM_TOGGLES; k++) begin
				if (press_mask[TOG_BUTTON[k]]) begin
					nxt.led[TOG_BUTTON[k]]   = 1'b1;
					nxt.relay[TOG_RELAY[k]-1] = ~nxt.relay[TOG_RELAY[k]-1];
				end else if (release_mask[TOG_BUTTON[k]]) begin
					lvl = nxt.relay[TOG_RELAY[k]-1];
					nxt.led[TOG_BUTTON[k]] = lvl;
					if (TOG_BUTTON[k] == B_BATH1) nxt.led[B_BATH2] = lvl;
					if (TOG_BUTTON[k] == B_BATH2) nxt.led[B_BATH1] = lvl;
				end
			end
			if (press_mask[B_MASTER]) begin
				nxt.led[B_MASTER] = 1'b1;
				nxt.master        = 1'b1;
			end else if (release_mask[B_MASTER]) begin
				nxt.led[B_MASTER] = 1'b0;
				nxt.master        = 1'b0;
			end
			if (press_mask[B_SPARE_A]) nxt.led[B_SPARE_A] = ~nxt.led[B_SPARE_A];
			if (press_mask[B_SPARE_B]) nxt.led[B_SPARE_B] = ~nxt.led[B_SPARE_B];
			if (press_mask[B_MUR_IN] && !state_q.dnd) begin
				lvl = ~nxt.led[B_MUR_IN];
				nxt.led[B_MUR_IN]  = lvl;
				nxt.led[B_MUR_OUT] = lvl;
			end
			if (press_mask[B_DND_IN]) begin
				lvl = ~nxt.led[B_DND_IN];
				nxt.led[B_DND_IN]  = lvl;
				nxt.led[B_DND_OUT] = lvl;
				nxt.led[B_MUR_IN]  = 1'b0;
				nxt.led[B_MUR_OUT] = 1'b0;
				nxt.dnd            = ~state_q.dnd;
			end
			if (press_mask[B_SPARE_C]) nxt.led[B_SPARE_C] = ~nxt.led[B_SPARE_C];
			if (press_mask[B_SPARE_D]) nxt.led[B_SPARE_D] = ~nxt.led[B_SPARE_D];
			if (press_mask[B_CARD]) begin
				nxt.abs_cnt      = '0;
				nxt.card_present = 1'b1;
			end else if (release_mask[B_CARD]) begin
				nxt.card_present = 1'b0;
			end
			// Held master forces loads off but welcome relays A and B, lobby light on, DND cleared
			if (nxt.master) begin
				nxt.relay = (nxt.relay & MASTER_RLY_KEEP) | rly(R_LOBBY);
				nxt.led   = (nxt.led & MASTER_LED_KEEP) | btn(B_SL1);
				nxt.dnd   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= nxt;
		end
	end

	assign state = state_q;

endmodule

// File: rtl/room_relay_keycard_controller_core.sv
// Channel   Direction  Payload (lowest bit first)
// s_*       in         tuser: operation; tdata: press_mask, release_mask
// m_*       out        tdata: relay_drive, indicator_leds
// cfg_*     in         cfg_index selects the register, cfg_data its 24-bit value
//
// One item per cycle sustained while the result is not stalled; each result is registered.
// Input register, then the room state update in one pass into the result register.
// Reset clears the room state's relays, LEDs and all timers; config registers return to their defaults.
// A stalled result holds the input stage, which stops taking items once full.
// Configuration writes complete in the cycle they are offered.
`include "room_relay_keycard_controller_core_macros.svh"

module room_relay_keycard_controller_core
	import rrkc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [47:0]          s_tdata,    // press_mask, release_mask
	input  logic                 s_tuser,    // operation
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,    // relay_drive, indicator_leds
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	logic                   valid_s1;
	op_t                    op_s1;
	logic [NUM_BUTTONS-1:0] press_s1;
	logic [NUM_BUTTONS-1:0] release_s1;
	logic                   adv;
	logic                   m_valid_q;
	logic [NUM_RELAYS-1:0]  relay_q;
	logic [NUM_BUTTONS-1:0] led_q;
	cfg_t                   cfg;
	ctl_state_t             state;
	ctl_state_t             nxt;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv;

	rrkc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1      <= op_t'(s_tuser);
			press_s1   <= s_tdata[23:0];
			release_s1 <= s_tdata[47:24];
		end
	end

	rrkc_room_state u_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.op           (op_s1),
		.press_mask   (press_s1),
		.release_mask (release_s1),
		.cfg          (cfg),
		.state        (state),
		.nxt          (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			relay_q <= nxt.relay;
			led_q   <= nxt.led;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {led_q, relay_q};

	`RRKC_ASSERT_NEXT(a_adv_gives_result, adv, m_tvalid, "advanced item produced no result")
	`RRKC_ASSERT_NOW(a_ready_when_out_free, !m_valid_q, s_tready, "input stalled with free output")
	`RRKC_ASSERT_NOW(a_bell_idle_count, !state.bell_run, state.bell_cnt == '0, "bell count left over")
	`RRKC_ASSERT_NOW(a_card_absent_count, state.card_present, state.abs_cnt == '0, "absence counted with card in")

endmodule
